// File: rtl/lru_key_value_cache_core_macros.svh
// Assertion macros for the LRU key-value cache checker.
// Depends on nothing; the including module supplies i_clk and i_rst_n.
`ifndef LRU_KEY_VALUE_CACHE_CORE_MACROS_SVH
`define LRU_KEY_VALUE_CACHE_CORE_MACROS_SVH

// Consequent in the cycle after the antecedent.
`define LKVC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lru cache check failed");

// Consequent in the same cycle as the antecedent.
`define LKVC_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lru cache check failed");

`endif

// File: rtl/lkvc_pkg.sv
// Shared types and constants for the LRU key-value cache.
// Used by lkvc_cell and lru_key_value_cache_core; depends on nothing.
package lkvc_pkg;

    localparam int MAX_ENTRIES = 8;
    localparam int DATA_W      = 32;
    localparam int CAP_W       = 4;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int CMP_W       = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam int CAP_RESET   = 8;

    typedef enum logic {
        OP_GET = 1'b0,
        OP_SET = 1'b1
    } t_op;

    typedef logic [DATA_W-1:0] t_data;
    typedef logic [CNT_W-1:0]  t_cnt;
    typedef logic [CAP_W-1:0]  t_cap;
    typedef logic [CMP_W-1:0]  t_cmp;

    // Broadcast from the controller to every cell.
    typedef struct packed {
        logic  upd;    // request in its update cycle
        logic  hit;    // key found somewhere in the row
        logic  set;    // request is a set
        logic  evict;  // miss set that drops the oldest entry
        t_data key;    // request key
    } t_cell_ctl;

endpackage

// File: rtl/lkvc_cell.sv
// One recency slot of the LRU row: key, value, valid, plus ripple chains.
// Depends on lkvc_pkg.
module lkvc_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  lkvc_pkg::t_cell_ctl i_ctl,
    // newer neighbor (or the front entry for slot 0)
    input  lkvc_pkg::t_data     i_prev_key,
    input  lkvc_pkg::t_data     i_prev_value,
    input  logic                i_prev_valid,
    // older neighbor
    input  logic                i_next_valid,
    input  logic                i_below_match,
    input  lkvc_pkg::t_data     i_below_value,
    input  lkvc_pkg::t_data     i_below_evkey,
    output lkvc_pkg::t_data     o_key,
    output lkvc_pkg::t_data     o_value,
    output logic                o_valid,
    output logic                o_below_match,
    output lkvc_pkg::t_data     o_below_value,
    output lkvc_pkg::t_data     o_below_evkey
);

    lkvc_pkg::t_data r_key;
    lkvc_pkg::t_data r_value;
    logic            r_valid;
    logic            match;
    logic            last;
    logic            take;

    assign match = r_valid && (r_key == i_ctl.key);
    assign last  = r_valid && !i_next_valid;

    // match chain: set if this slot or any older one matches
    assign o_below_match = match | i_below_match;
    assign o_below_value = match ? r_value : i_below_value;
    assign o_below_evkey = last ? r_key : i_below_evkey;

    // hit: slots up to the matching one move down one place
    // miss set with eviction: every valid slot moves, the oldest drops off
    // miss set without eviction: valid slots plus the first free one move
    always_comb begin
        take = 1'b0;
        if (i_ctl.upd) begin
            if (i_ctl.hit) begin
                take = o_below_match;
            end else if (i_ctl.set) begin
                take = i_ctl.evict ? r_valid : i_prev_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= i_prev_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_key   <= i_prev_key;
            r_value <= i_prev_value;
        end
    end

    assign o_key   = r_key;
    assign o_value = r_value;
    assign o_valid = r_valid;

endmodule

// File: rtl/lru_key_value_cache_core.sv
// Top level of the LRU key-value cache: request register, control, cell row.
// Depends on lkvc_pkg and lkvc_cell.
//
// Usage:
//  - Request channel: drive i_operation (0 get, 1 set), i_key, i_value and
//    raise start. The request is taken at an edge where start is high and
//    busy is low; busy is then high for one cycle.
//  - Result channel: o_valid is high for exactly one cycle with o_hit,
//    o_read_value, o_evicted and o_evicted_key. The receiver cannot stall
//    and must take the result in that cycle.
//  - Result timing: the accepting edge registers the request and raises
//    busy; the edge that ends busy loads the result and raises o_valid.
//  - Overlap: no new request is taken while busy. The compare, the match and
//    eviction ripple through the row of eight cells and the shift of the
//    row all happen in the update cycle; the accept cycle only
//    registers the request.
//  - Configuration: i_cfg_we writes i_cfg_wdata into the capacity register
//    (reset value 8; 0 acts as 1, values above the row length as the row
//    length). Write it only while idle.
//  - Reset (synchronous, active low): all slots invalid, fill count zero,
//    capacity 8, no result pending. Slot keys and values are not cleared.
//  - Slot 0 of the row is the most recent entry; the row shifts toward
//    higher slots as new entries come in.
module lru_key_value_cache_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_operation,
    input  logic signed [31:0] i_key,
    input  logic signed [31:0] i_value,
    input  logic               i_cfg_we,
    input  logic [3:0]         i_cfg_wdata,
    output logic               o_valid,
    output logic               o_hit,
    output logic signed [31:0] o_read_value,
    output logic               o_evicted,
    output logic signed [31:0] o_evicted_key
);

    localparam int N = lkvc_pkg::MAX_ENTRIES;

    // request register
    logic               r_pend;
    lkvc_pkg::t_op      r_op;
    lkvc_pkg::t_data    r_key;
    lkvc_pkg::t_data    r_value;

    // state kept outside the row
    lkvc_pkg::t_cap     r_cap;
    lkvc_pkg::t_cnt     r_fill;
    lkvc_pkg::t_cnt     n_fill;

    // result registers
    logic               r_valid;
    logic               r_hit;
    lkvc_pkg::t_data    r_read_value;
    logic               r_evicted;
    lkvc_pkg::t_data    r_evicted_key;

    // row wiring: index 0 of the prev arrays is the front entry,
    // index j+1 is cell j; index N of the below chains is the row end
    lkvc_pkg::t_data    prev_key   [N+1];
    lkvc_pkg::t_data    prev_value [N+1];
    logic               prev_valid [N+1];
    logic               chain_match [N+1];
    lkvc_pkg::t_data    chain_value [N+1];
    lkvc_pkg::t_data    chain_evkey [N+1];

    lkvc_pkg::t_cell_ctl ctl;
    lkvc_pkg::t_cmp      cap_x;
    lkvc_pkg::t_cmp      eff_cap;
    logic                hit;
    logic                is_set;
    logic                evict;
    logic                accept;

    assign accept = start && !busy;
    assign busy   = r_pend;

    // saturate the capacity to 1..N
    assign cap_x = lkvc_pkg::t_cmp'(r_cap);
    always_comb begin
        eff_cap = cap_x;
        if (cap_x == '0) begin
            eff_cap = lkvc_pkg::t_cmp'(1);
        end else if (cap_x > lkvc_pkg::t_cmp'(N)) begin
            eff_cap = lkvc_pkg::t_cmp'(N);
        end
    end

    assign hit    = chain_match[0];
    assign is_set = (r_op == lkvc_pkg::OP_SET);
    assign evict  = is_set && !hit && (lkvc_pkg::t_cmp'(r_fill) >= eff_cap);

    assign ctl.upd   = r_pend;
    assign ctl.hit   = hit;
    assign ctl.set   = is_set;
    assign ctl.evict = evict;
    assign ctl.key   = r_key;

    // front entry: what slot 0 takes in the update cycle
    assign prev_key[0]   = r_key;
    assign prev_value[0] = is_set ? r_value : chain_value[0];
    assign prev_valid[0] = 1'b1;

    assign chain_match[N] = 1'b0;
    assign chain_value[N] = '0;
    assign chain_evkey[N] = '0;

    for (genvar j = 0; j < N; j++) begin : g_row
        logic next_valid;
        if (j == N - 1) begin : g_end
            assign next_valid = 1'b0;
        end else begin : g_mid
            assign next_valid = prev_valid[j+2];
        end

        lkvc_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctl         (ctl),
            .i_prev_key    (prev_key[j]),
            .i_prev_value  (prev_value[j]),
            .i_prev_valid  (prev_valid[j]),
            .i_next_valid  (next_valid),
            .i_below_match (chain_match[j+1]),
            .i_below_value (chain_value[j+1]),
            .i_below_evkey (chain_evkey[j+1]),
            .o_key         (prev_key[j+1]),
            .o_value       (prev_value[j+1]),
            .o_valid       (prev_valid[j+1]),
            .o_below_match (chain_match[j]),
            .o_below_value (chain_value[j]),
            .o_below_evkey (chain_evkey[j])
        );
    end

    // fill count grows only on a miss set that keeps every entry
    always_comb begin
        n_fill = r_fill;
        if (r_pend && is_set && !hit && !evict) begin
            n_fill = r_fill + lkvc_pkg::t_cnt'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend  <= 1'b0;
            r_valid <= 1'b0;
            r_fill  <= '0;
            r_cap   <= lkvc_pkg::t_cap'(lkvc_pkg::CAP_RESET);
        end else begin
            r_pend  <= accept;
            r_valid <= r_pend;
            r_fill  <= n_fill;
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op    <= lkvc_pkg::t_op'(i_operation);
            r_key   <= i_key;
            r_value <= i_value;
        end
        if (r_pend) begin
            r_hit         <= hit;
            r_evicted     <= evict;
            r_evicted_key <= evict ? chain_evkey[0] : '0;
            if (is_set) begin
                r_read_value <= r_value;
            end else if (hit) begin
                r_read_value <= chain_value[0];
            end else begin
                r_read_value <= '1;
            end
        end
    end

    assign o_valid       = r_valid;
    assign o_hit         = r_hit;
    assign o_read_value  = r_read_value;
    assign o_evicted     = r_evicted;
    assign o_evicted_key = r_evicted_key;

endmodule

// File: rtl/lkvc_checker.sv
// Port-level checks for lru_key_value_cache_core, attached by bind.
// Depends on lru_key_value_cache_core_macros.svh.
`include "lru_key_value_cache_core_macros.svh"

module lkvc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_valid,
    input logic        o_hit,
    input logic        o_evicted,
    input logic [31:0] o_evicted_key
);

    // an accepted request blocks the next cycle
    `LKVC_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
    // busy lasts one cycle and ends in the result
    `LKVC_ASSERT_NEXT(a_busy_result, busy, !busy && o_valid)
    // a result only follows a busy cycle
    `LKVC_ASSERT_SAME(a_result_src, o_valid, !busy && $past(busy))
    // an eviction never comes with a hit
    `LKVC_ASSERT_SAME(a_evict_miss, o_valid && o_evicted, !o_hit)
    // a result without an eviction reports a zero key
    `LKVC_ASSERT_SAME(a_evkey_zero, o_valid && !o_evicted, o_evicted_key == 32'd0)

endmodule

bind lru_key_value_cache_core lkvc_checker u_lkvc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .o_valid       (o_valid),
    .o_hit         (o_hit),
    .o_evicted     (o_evicted),
    .o_evicted_key (o_evicted_key)
);
